>>> rtl/core/tkpms_pkg.sv
// Package for the two-kind pair matching stack: item structs, stack codes,
// symbol constants and the shift control struct. No dependencies.
`timescale 1ns / 1ps

package tkpms_pkg;

  localparam int unsigned StackDepth = 1024;
  localparam int unsigned LevelW     = $clog2(StackDepth) + 1;
  localparam int unsigned CountW     = 13;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  localparam logic [7:0] SymSep     = 8'h40;  // '@'
  localparam logic [7:0] SymUpOpen  = 8'h48;  // 'H'
  localparam logic [7:0] SymLoOpen  = 8'h68;  // 'h'
  localparam logic [7:0] SymUpClose = 8'h4D;  // 'M'
  localparam logic [7:0] SymLoClose = 8'h6D;  // 'm'

  typedef enum logic [1:0] {
    CodeUpOpen  = 2'd0,
    CodeLoOpen  = 2'd1,
    CodeUpClose = 2'd2,
    CodeLoClose = 2'd3
  } code_e;

  typedef struct packed {
    logic [7:0] symbol;
    logic       last_of_sequence;
  } in_item_t;

  typedef struct packed {
    logic [CountW-1:0] pair_count;
    logic              overflow;
  } out_item_t;

  typedef struct packed {
    logic  push;
    logic  pop;
    code_e code;
  } shift_ctrl_t;

endpackage

>>> rtl/core/tkpms_cell.sv
// One stack cell: holds a single 2-bit entry and shifts with its neighbors.
// Depends on tkpms_pkg.
`timescale 1ns / 1ps

module tkpms_cell (
  input  logic                      clk_i,
  input  tkpms_pkg::shift_ctrl_t    ctrl_i,
  input  tkpms_pkg::code_e          shallower_i,
  input  tkpms_pkg::code_e          deeper_i,
  output tkpms_pkg::code_e          entry_o
);

  tkpms_pkg::code_e entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.push) begin
      entry_d = shallower_i;
    end else if (ctrl_i.pop) begin
      entry_d = deeper_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

>>> rtl/core/tkpms_chain.sv
// Row of stack cells with the top of stack in cell zero.
// Depends on tkpms_pkg and tkpms_cell.
`timescale 1ns / 1ps

module tkpms_chain (
  input  logic                   clk_i,
  input  tkpms_pkg::shift_ctrl_t ctrl_i,
  output tkpms_pkg::code_e       top_o
);

  tkpms_pkg::code_e entry [tkpms_pkg::StackDepth];

  for (genvar i = 0; i < tkpms_pkg::StackDepth; i++) begin : g_cell
    tkpms_pkg::code_e shallower, deeper;

    // Cell zero takes the new code on push; the deepest cell refills itself on pop.
    if (i == 0) begin : g_head
      assign shallower = ctrl_i.code;
    end else begin : g_body
      assign shallower = entry[i-1];
    end
    if (i == tkpms_pkg::StackDepth - 1) begin : g_tail
      assign deeper = entry[i];
    end else begin : g_inner
      assign deeper = entry[i+1];
    end

    tkpms_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl_i),
      .shallower_i (shallower),
      .deeper_i    (deeper),
      .entry_o     (entry[i])
    );
  end

  assign top_o = entry[0];

endmodule

>>> rtl/core/two_kind_pair_matching_stack_top.sv
// A result is valid in the cycle after its last item is accepted.
// Throughput: one item per cycle; the top of stack sits in cell zero of a
// shifting cell chain, so the match decision needs only that register and the level.
// Input stalls only while a finished result waits in the output register.
// Reset clears level, pair count, overflow flag and output valid; cells are not reset.
// Top level; depends on tkpms_pkg and tkpms_chain.
`timescale 1ns / 1ps

module two_kind_pair_matching_stack_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tkpms_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tkpms_pkg::out_item_t out_item_o
);

  localparam logic [tkpms_pkg::LevelW-1:0] LevelFull =
    tkpms_pkg::LevelW'(tkpms_pkg::StackDepth);

  logic [tkpms_pkg::LevelW-1:0] level_q, level_d;
  logic [tkpms_pkg::CountW-1:0] pairs_q, pairs_d, pairs_upd;
  logic                         ovf_q, ovf_d, ovf_upd;
  logic                         out_valid_q, out_valid_d;
  tkpms_pkg::out_item_t         out_item_q, out_item_d;
  tkpms_pkg::shift_ctrl_t       ctrl;
  tkpms_pkg::code_e             top;
  logic                         accept;
  logic                         want_push, match;
  logic [tkpms_pkg::LevelW-1:0] level_upd;

  tkpms_chain u_chain (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .top_o  (top)
  );

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    want_push = 1'b0;
    match     = 1'b0;
    ctrl.code = tkpms_pkg::CodeUpOpen;
    level_upd = level_q;
    unique case (in_item_i.symbol)
      tkpms_pkg::SymSep: level_upd = '0;
      tkpms_pkg::SymUpOpen: begin
        want_push = 1'b1;
        ctrl.code = tkpms_pkg::CodeUpOpen;
      end
      tkpms_pkg::SymLoOpen: begin
        want_push = 1'b1;
        ctrl.code = tkpms_pkg::CodeLoOpen;
      end
      tkpms_pkg::SymUpClose: begin
        match     = (level_q != '0) && (top == tkpms_pkg::CodeUpOpen);
        want_push = !match;
        ctrl.code = tkpms_pkg::CodeUpClose;
      end
      tkpms_pkg::SymLoClose: begin
        match     = (level_q != '0) && (top == tkpms_pkg::CodeLoOpen);
        want_push = !match;
        ctrl.code = tkpms_pkg::CodeLoClose;
      end
      default: ;
    endcase

    // Drop a push onto a full stack and flag it.
    ctrl.push = accept && want_push && (level_q != LevelFull);
    ctrl.pop  = accept && match;
    ovf_upd   = ovf_q || (want_push && (level_q == LevelFull));
    pairs_upd = pairs_q;
    if (match) begin
      level_upd = level_q - tkpms_pkg::LevelW'(1);
      if (pairs_q != tkpms_pkg::CountMax) begin
        pairs_upd = pairs_q + tkpms_pkg::CountW'(1);
      end
    end else if (want_push && (level_q != LevelFull)) begin
      level_upd = level_q + tkpms_pkg::LevelW'(1);
    end

    level_d     = level_q;
    pairs_d     = pairs_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    if (accept) begin
      if (in_item_i.last_of_sequence) begin
        level_d                = '0;
        pairs_d                = '0;
        ovf_d                  = 1'b0;
        out_valid_d            = 1'b1;
        out_item_d.pair_count  = pairs_upd;
        out_item_d.overflow    = ovf_upd;
      end else begin
        level_d = level_upd;
        pairs_d = pairs_upd;
        ovf_d   = ovf_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q     <= '0;
      pairs_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      level_q     <= level_d;
      pairs_q     <= pairs_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_level_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LevelFull)
    else $error("stack level beyond depth");

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.pop |-> (level_q != '0) && !ctrl.push)
    else $error("pop on empty stack or with push");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_item_i.last_of_sequence |=> out_valid_q && pairs_q == '0 && level_q == '0)
    else $error("last item did not produce a result and clear state");

  a_count_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !in_item_i.last_of_sequence |=>
      pairs_q == $past(pairs_q) || pairs_q == $past(pairs_q) + tkpms_pkg::CountW'(1))
    else $error("pair count jumped");

  a_stall_only_on_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_q && !out_ready_i)
    else $error("input stalled without a waiting result");

endmodule
